@@ sv/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Item formats, datapath widths and stage counts for the rotation matrix to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Field widths
    localparam int MW   = 16;          // matrix entry, Q2.14
    localparam int SHW  = 32;          // translation, Q16.16
    localparam int TW   = 18;          // trace candidate
    localparam int DW   = 17;          // off-diagonal sum or difference
    localparam int UW   = 17;          // magnitude of one vector component
    localparam int SQW  = 2 * UW;      // square of one component
    localparam int SW   = SQW + 2;     // sum of four squares
    localparam int RW   = SW / 2;      // integer square root
    localparam int REMW = RW + 2;      // square root remainder
    localparam int DVW  = RW + 1;      // divisor 2*r
    localparam int QW   = 16;          // quotient bits, one per divide stage
    localparam int NW   = UW + QW;     // dividend mag*2^15 + r
    localparam int NL   = 4;           // quaternion lanes

    // Pipeline layout: front end, square root, divide, output register
    localparam int FRONT   = 4;
    localparam int SQ_BASE = FRONT;
    localparam int DV_BASE = SQ_BASE + RW;
    localparam int NST     = DV_BASE + QW + 1;

    localparam logic signed [TW-1:0] ONE_Q14 = TW'(16384);

    // Pick codes
    typedef enum logic [1:0] {
        PICK_W = 2'd0,
        PICK_X = 2'd1,
        PICK_Y = 2'd2,
        PICK_Z = 2'd3
    } t_pick;

    typedef struct packed {
        logic signed [MW-1:0]  m_0_0;
        logic signed [MW-1:0]  m_0_1;
        logic signed [MW-1:0]  m_0_2;
        logic signed [MW-1:0]  m_1_0;
        logic signed [MW-1:0]  m_1_1;
        logic signed [MW-1:0]  m_1_2;
        logic signed [MW-1:0]  m_2_0;
        logic signed [MW-1:0]  m_2_1;
        logic signed [MW-1:0]  m_2_2;
        logic signed [SHW-1:0] shift_x;
        logic signed [SHW-1:0] shift_y;
        logic signed [SHW-1:0] shift_z;
    } t_in_item;

    typedef struct packed {
        logic signed [MW-1:0]  quat_w;
        logic signed [MW-1:0]  quat_x;
        logic signed [MW-1:0]  quat_y;
        logic signed [MW-1:0]  quat_z;
        logic signed [SHW-1:0] out_shift_x;
        logic signed [SHW-1:0] out_shift_y;
        logic signed [SHW-1:0] out_shift_z;
        logic                  bad_matrix;
    } t_out_item;

    // Candidates and off-diagonal terms after the first stage
    typedef struct packed {
        logic signed [TW-1:0]  t0;
        logic signed [TW-1:0]  t1;
        logic signed [TW-1:0]  t2;
        logic signed [TW-1:0]  t3;
        logic signed [DW-1:0]  d12m21;
        logic signed [DW-1:0]  d20m02;
        logic signed [DW-1:0]  d01m10;
        logic signed [DW-1:0]  s01p10;
        logic signed [DW-1:0]  s20p02;
        logic signed [DW-1:0]  s12p21;
        logic signed [SHW-1:0] sx;
        logic signed [SHW-1:0] sy;
        logic signed [SHW-1:0] sz;
    } t_s0;

    // Per-item context carried down the pipeline
    typedef struct packed {
        logic [NL-1:0][UW-1:0] mag;
        logic [NL-1:0]         neg;
        logic                  bad;
        logic signed [SHW-1:0] sx;
        logic signed [SHW-1:0] sy;
        logic signed [SHW-1:0] sz;
    } t_ctx;

endpackage

@@ sv/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq_if: valid/ready channel
// Carries one item per handshake; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface rmq_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Q2.14 rotation matrix to unit quaternion
// Picks the largest trace candidate, builds the scaled quaternion vector,
// and normalizes it with a pipelined square root and four pipelined dividers.
// ----------------------------------------------------------------------------
// The block takes one matrix item per clock unless an output stall has backed up
// to the input, and returns one result item per item, in order. Each item passes
// 39 register stages: the digit-by-digit square root of the 36-bit squared
// norm (18 stages, one root bit each) and the restoring dividers (16 stages,
// one quotient bit each), behind four front stages (candidates, pick,
// squares, sum) and one output register. Every stage holds its own valid
// bit and fills bubbles, so a stall at the output only backs up as far as
// needed and the translation passes through unchanged.
module rotation_matrix_to_quaternion (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rmq_if.sink   i_in,
    rmq_if.source o_out
);

    localparam int LAST = rmq_pkg::NST - 1;

    logic [rmq_pkg::NST-1:0] r_vld;
    logic [rmq_pkg::NST-1:0] en;

    // Stage enables: a stage loads when it is empty or its successor loads
    assign en[LAST] = !r_vld[LAST] || o_out.ready;
    genvar gi;
    generate
        for (gi = 0; gi < LAST; gi++) begin : g_en
            assign en[gi] = !r_vld[gi] || en[gi+1];
        end
    endgenerate

    assign i_in.ready = en[0];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < rmq_pkg::NST; i++) begin
                if (en[i]) begin
                    r_vld[i] <= (i == 0) ? i_in.valid : r_vld[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // ---------------- Stage 0: trace candidates and off-diagonal terms
    rmq_pkg::t_s0 n_s0, r_s0;

    always_comb begin
        n_s0.t0 = rmq_pkg::ONE_Q14 + rmq_pkg::TW'(i_in.data.m_0_0)
                + rmq_pkg::TW'(i_in.data.m_1_1) + rmq_pkg::TW'(i_in.data.m_2_2);
        n_s0.t1 = rmq_pkg::ONE_Q14 + rmq_pkg::TW'(i_in.data.m_0_0)
                - rmq_pkg::TW'(i_in.data.m_1_1) - rmq_pkg::TW'(i_in.data.m_2_2);
        n_s0.t2 = rmq_pkg::ONE_Q14 - rmq_pkg::TW'(i_in.data.m_0_0)
                + rmq_pkg::TW'(i_in.data.m_1_1) - rmq_pkg::TW'(i_in.data.m_2_2);
        n_s0.t3 = rmq_pkg::ONE_Q14 - rmq_pkg::TW'(i_in.data.m_0_0)
                - rmq_pkg::TW'(i_in.data.m_1_1) + rmq_pkg::TW'(i_in.data.m_2_2);
        n_s0.d12m21 = rmq_pkg::DW'(i_in.data.m_1_2) - rmq_pkg::DW'(i_in.data.m_2_1);
        n_s0.d20m02 = rmq_pkg::DW'(i_in.data.m_2_0) - rmq_pkg::DW'(i_in.data.m_0_2);
        n_s0.d01m10 = rmq_pkg::DW'(i_in.data.m_0_1) - rmq_pkg::DW'(i_in.data.m_1_0);
        n_s0.s01p10 = rmq_pkg::DW'(i_in.data.m_0_1) + rmq_pkg::DW'(i_in.data.m_1_0);
        n_s0.s20p02 = rmq_pkg::DW'(i_in.data.m_2_0) + rmq_pkg::DW'(i_in.data.m_0_2);
        n_s0.s12p21 = rmq_pkg::DW'(i_in.data.m_1_2) + rmq_pkg::DW'(i_in.data.m_2_1);
        n_s0.sx = i_in.data.shift_x;
        n_s0.sy = i_in.data.shift_y;
        n_s0.sz = i_in.data.shift_z;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= n_s0;
        end
    end

    // ---------------- Stage 1: pick largest candidate, form vector magnitudes
    rmq_pkg::t_ctx n_s1, r_s1;

    always_comb begin
        logic signed [rmq_pkg::TW-1:0] tv [rmq_pkg::NL];
        logic signed [rmq_pkg::TW-1:0] u  [rmq_pkg::NL];
        logic signed [rmq_pkg::TW-1:0] best;
        rmq_pkg::t_pick                pick;
        logic                          found;

        tv[0] = r_s0.t0;
        tv[1] = r_s0.t1;
        tv[2] = r_s0.t2;
        tv[3] = r_s0.t3;
        best  = -rmq_pkg::ONE_Q14;
        pick  = rmq_pkg::PICK_W;
        found = 1'b0;
        // Strict compare keeps the lower index on a tie
        for (int i = 0; i < rmq_pkg::NL; i++) begin
            if (best < tv[i]) begin
                best  = tv[i];
                pick  = rmq_pkg::t_pick'(i[1:0]);
                found = 1'b1;
            end
        end

        case (pick)
            rmq_pkg::PICK_W: begin
                u[0] = r_s0.t0;
                u[1] = rmq_pkg::TW'(r_s0.d12m21);
                u[2] = rmq_pkg::TW'(r_s0.d20m02);
                u[3] = rmq_pkg::TW'(r_s0.d01m10);
            end
            rmq_pkg::PICK_X: begin
                u[0] = rmq_pkg::TW'(r_s0.d12m21);
                u[1] = r_s0.t1;
                u[2] = rmq_pkg::TW'(r_s0.s01p10);
                u[3] = rmq_pkg::TW'(r_s0.s20p02);
            end
            rmq_pkg::PICK_Y: begin
                u[0] = rmq_pkg::TW'(r_s0.d20m02);
                u[1] = rmq_pkg::TW'(r_s0.s01p10);
                u[2] = r_s0.t2;
                u[3] = rmq_pkg::TW'(r_s0.s12p21);
            end
            default: begin
                u[0] = rmq_pkg::TW'(r_s0.d01m10);
                u[1] = rmq_pkg::TW'(r_s0.s20p02);
                u[2] = rmq_pkg::TW'(r_s0.s12p21);
                u[3] = r_s0.t3;
            end
        endcase

        for (int i = 0; i < rmq_pkg::NL; i++) begin
            n_s1.neg[i] = found & u[i][rmq_pkg::TW-1];
            if (!found) begin
                n_s1.mag[i] = '0;
            end else if (u[i][rmq_pkg::TW-1]) begin
                n_s1.mag[i] = rmq_pkg::UW'(-u[i]);
            end else begin
                n_s1.mag[i] = rmq_pkg::UW'(u[i]);
            end
        end
        n_s1.bad = !found;
        n_s1.sx  = r_s0.sx;
        n_s1.sy  = r_s0.sy;
        n_s1.sz  = r_s0.sz;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- Stage 2: square each component
    logic [rmq_pkg::SQW-1:0] r_s2_sq [rmq_pkg::NL];
    rmq_pkg::t_ctx           r_s2_ctx;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < rmq_pkg::NL; i++) begin
                r_s2_sq[i] <= rmq_pkg::SQW'(r_s1.mag[i]) * rmq_pkg::SQW'(r_s1.mag[i]);
            end
            r_s2_ctx <= r_s1;
        end
    end

    // ---------------- Stage 3: squared norm
    logic [rmq_pkg::SW-1:0] r_s3_s;
    rmq_pkg::t_ctx          r_s3_ctx;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_s <= rmq_pkg::SW'(r_s2_sq[0]) + rmq_pkg::SW'(r_s2_sq[1])
                    + rmq_pkg::SW'(r_s2_sq[2]) + rmq_pkg::SW'(r_s2_sq[3]);
            r_s3_ctx <= r_s2_ctx;
        end
    end

    // ---------------- Square root: one root bit per stage
    logic [rmq_pkg::REMW-1:0] r_sq_rem  [rmq_pkg::RW];
    logic [rmq_pkg::RW-1:0]   r_sq_root [rmq_pkg::RW];
    logic [rmq_pkg::SW-1:0]   r_sq_rest [rmq_pkg::RW];
    rmq_pkg::t_ctx            r_sq_ctx  [rmq_pkg::RW];

    generate
        for (gi = 0; gi < rmq_pkg::RW; gi++) begin : g_sqrt
            logic [rmq_pkg::REMW-1:0] p_rem;
            logic [rmq_pkg::RW-1:0]   p_root;
            logic [rmq_pkg::SW-1:0]   p_rest;
            rmq_pkg::t_ctx            p_ctx;
            logic [rmq_pkg::REMW+1:0] remx;
            logic [rmq_pkg::REMW+1:0] trial;

            if (gi == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rest = r_s3_s;
                assign p_ctx  = r_s3_ctx;
            end else begin : g_next
                assign p_rem  = r_sq_rem[gi-1];
                assign p_root = r_sq_root[gi-1];
                assign p_rest = r_sq_rest[gi-1];
                assign p_ctx  = r_sq_ctx[gi-1];
            end

            // Bring down the next two bits and try root*4+1
            assign remx  = {p_rem, p_rest[rmq_pkg::SW-1 -: 2]};
            assign trial = (rmq_pkg::REMW + 2)'({p_root, 2'b01});

            always_ff @(posedge i_clk) begin
                if (en[rmq_pkg::SQ_BASE + gi]) begin
                    if (remx >= trial) begin
                        r_sq_rem[gi]  <= rmq_pkg::REMW'(remx - trial);
                        r_sq_root[gi] <= {p_root[rmq_pkg::RW-2:0], 1'b1};
                    end else begin
                        r_sq_rem[gi]  <= rmq_pkg::REMW'(remx);
                        r_sq_root[gi] <= {p_root[rmq_pkg::RW-2:0], 1'b0};
                    end
                    r_sq_rest[gi] <= {p_rest[rmq_pkg::SW-3:0], 2'b00};
                    r_sq_ctx[gi]  <= p_ctx;
                end
            end
        end
    endgenerate

    // ---------------- Divide: (2*mag*2^14 + r) / (2*r), one quotient bit per stage
    logic [rmq_pkg::DVW-1:0] r_dv_rem [rmq_pkg::QW][rmq_pkg::NL];
    logic [rmq_pkg::QW-1:0]  r_dv_q   [rmq_pkg::QW][rmq_pkg::NL];
    logic [rmq_pkg::DVW-1:0] r_dv_d   [rmq_pkg::QW];
    rmq_pkg::t_ctx           r_dv_ctx [rmq_pkg::QW];

    generate
        for (gi = 0; gi < rmq_pkg::QW; gi++) begin : g_div
            logic [rmq_pkg::DVW-1:0] p_rem [rmq_pkg::NL];
            logic [rmq_pkg::QW-1:0]  p_q   [rmq_pkg::NL];
            logic [rmq_pkg::DVW-1:0] p_d;
            rmq_pkg::t_ctx           p_ctx;

            if (gi == 0) begin : g_first
                logic [rmq_pkg::RW-1:0] root;
                assign root  = r_sq_root[rmq_pkg::RW-1];
                assign p_d   = {root, 1'b0};
                assign p_ctx = r_sq_ctx[rmq_pkg::RW-1];
                // Quotient fits in QW bits, so the top part starts below the divisor
                for (genvar l = 0; l < rmq_pkg::NL; l++) begin : g_lane
                    logic [rmq_pkg::NW-1:0] num;
                    assign num = {p_ctx.mag[l], {(rmq_pkg::QW - 1){1'b0}}}
                               + rmq_pkg::NW'(root);
                    assign p_rem[l] = rmq_pkg::DVW'(num[rmq_pkg::NW-1:rmq_pkg::QW]);
                    assign p_q[l]   = num[rmq_pkg::QW-1:0];
                end
            end else begin : g_next
                assign p_d   = r_dv_d[gi-1];
                assign p_ctx = r_dv_ctx[gi-1];
                for (genvar l = 0; l < rmq_pkg::NL; l++) begin : g_lane
                    assign p_rem[l] = r_dv_rem[gi-1][l];
                    assign p_q[l]   = r_dv_q[gi-1][l];
                end
            end

            // Shift in the next dividend bit, subtract when it fits
            for (genvar l = 0; l < rmq_pkg::NL; l++) begin : g_step
                logic [rmq_pkg::DVW:0] remx;
                assign remx = {p_rem[l], p_q[l][rmq_pkg::QW-1]};

                always_ff @(posedge i_clk) begin
                    if (en[rmq_pkg::DV_BASE + gi]) begin
                        if (remx >= {1'b0, p_d}) begin
                            r_dv_rem[gi][l] <= rmq_pkg::DVW'(remx - {1'b0, p_d});
                            r_dv_q[gi][l]   <= {p_q[l][rmq_pkg::QW-2:0], 1'b1};
                        end else begin
                            r_dv_rem[gi][l] <= rmq_pkg::DVW'(remx);
                            r_dv_q[gi][l]   <= {p_q[l][rmq_pkg::QW-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[rmq_pkg::DV_BASE + gi]) begin
                    r_dv_d[gi]   <= p_d;
                    r_dv_ctx[gi] <= p_ctx;
                end
            end
        end
    endgenerate

    // ---------------- Output register: sign, saturate, zero on bad matrix
    rmq_pkg::t_out_item n_out, r_out;

    always_comb begin
        logic [rmq_pkg::MW-1:0] qv [rmq_pkg::NL];
        logic [rmq_pkg::QW-1:0] q;
        rmq_pkg::t_ctx          c;

        c = r_dv_ctx[rmq_pkg::QW-1];
        for (int l = 0; l < rmq_pkg::NL; l++) begin
            q = r_dv_q[rmq_pkg::QW-1][l];
            if (c.bad) begin
                qv[l] = '0;
            end else if (c.neg[l]) begin
                qv[l] = q[rmq_pkg::QW-1] ? {1'b1, {(rmq_pkg::MW - 1){1'b0}}}
                                         : rmq_pkg::MW'(~q + 1'b1);
            end else begin
                qv[l] = q[rmq_pkg::QW-1] ? {1'b0, {(rmq_pkg::MW - 1){1'b1}}}
                                         : rmq_pkg::MW'(q);
            end
        end
        n_out.quat_w      = qv[0];
        n_out.quat_x      = qv[1];
        n_out.quat_y      = qv[2];
        n_out.quat_z      = qv[3];
        n_out.out_shift_x = c.sx;
        n_out.out_shift_y = c.sy;
        n_out.out_shift_z = c.sz;
        n_out.bad_matrix  = c.bad;
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_vld[LAST];
    assign o_out.data  = r_out;

endmodule
